[rtl/core/vcms_pkg.sv]
// ----------------------------------------------------------------------------
// vcms_pkg
// Shared types, register codes and fixed-point widths for the central-mass
// Verlet step core.
// ----------------------------------------------------------------------------
package vcms_pkg;

    localparam int COORD_BITS        = 32;
    localparam int DEF_MAX_PARTICLES = 64;
    localparam int SLOT_BITS         = 6;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 48;

    // Arithmetic widths
    localparam int DT_BITS    = 24;
    localparam int GM_BITS    = 48;
    localparam int BOX_BITS   = 31;
    localparam int CNT_BITS   = 7;
    localparam int K_BITS     = 36;                 // G*M*dt^2, Q4.32
    localparam int D_BITS     = COORD_BITS + 1;     // center offset
    localparam int MUL_BITS   = K_BITS + D_BITS;    // shared multiplier product
    localparam int SQ_BITS    = 64;
    localparam int ROOT_BITS  = 32;
    localparam int DEN_BITS   = 3 * ROOT_BITS;
    localparam int DIV_SHIFT  = 37;
    localparam int QUO_BITS   = 42;                 // one bit above the cap
    localparam int TERM_BITS  = 41;
    localparam int SUM_BITS   = 44;

    localparam logic [TERM_BITS-1:0] TERM_CAP = TERM_BITS'(1) << (TERM_BITS - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TIME_STEP    = 3'd0,
        REG_CENTRAL_GM   = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_BOX_SIZE     = 3'd4,
        REG_ACTIVE_COUNT = 3'd5
    } cfg_reg_t;

    localparam logic [DT_BITS-1:0]    RST_TIME_STEP    = 24'd16384;
    localparam logic [GM_BITS-1:0]    RST_CENTRAL_GM   = 48'd1173936575;
    localparam logic [COORD_BITS-1:0] RST_CENTER_X     = 32'd83886080;
    localparam logic [COORD_BITS-1:0] RST_CENTER_Y     = 32'd83886080;
    localparam logic [BOX_BITS-1:0]   RST_BOX_SIZE     = 31'd167772160;
    localparam logic [CNT_BITS-1:0]   RST_ACTIVE_COUNT = 7'd64;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                          command;
        logic [SLOT_BITS-1:0]          slot;
        logic signed [COORD_BITS-1:0]  load_x;
        logic signed [COORD_BITS-1:0]  load_y;
        logic signed [COORD_BITS-1:0]  load_vx;
        logic signed [COORD_BITS-1:0]  load_vy;
    } req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]          out_slot;
        logic signed [COORD_BITS-1:0]  new_x;
        logic signed [COORD_BITS-1:0]  new_y;
        logic                          last_of_step;
    } rsp_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [COORD_BITS-1:0] prev_x;
        logic [COORD_BITS-1:0] prev_y;
        logic [COORD_BITS-1:0] vel_x;
        logic [COORD_BITS-1:0] vel_y;
    } entry_t;

endpackage

[rtl/core/verlet_central_mass_step_core.sv]
// ----------------------------------------------------------------------------
// verlet_central_mass_step_core
// Position-Verlet integrator for particles around one fixed central mass.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req_data): a load beat writes one
// particle's position and velocity into the particle RAM and marks it fresh;
// it returns nothing. A step beat advances particles 0 .. N-1, N being
// active_count capped at MAX_PARTICLES, in order and returns one response
// beat per particle, the final one flagged last_of_step.
// Configuration (cfg_we/cfg_index/cfg_data) is for the user to write only
// while the core idles; the block itself does not enforce this.
// A step first forms the gravity constant (S_K1, S_K2), then for each
// particle reads the RAM, runs the square root unit and two passes through
// the divider (x then y), plus multiply and wrap states. req_ready is low for
// the whole step; the next request is taken while the last response waits.
// When the receiver stalls, the core holds the pending response in its
// output register and waits before writing the next particle back.
// Reset restores the register defaults and marks every particle fresh; the
// RAM itself is not cleared.
// ----------------------------------------------------------------------------
module verlet_central_mass_step_core #(
    parameter int MAX_PARTICLES = vcms_pkg::DEF_MAX_PARTICLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  vcms_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output vcms_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_we,
    input  logic [vcms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vcms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import vcms_pkg::*;

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_PARTICLES);
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_K1   = 24'h000002,
        S_K2   = 24'h000004,
        S_RD   = 24'h000008,
        S_LD   = 24'h000010,
        S_SQX  = 24'h000020,
        S_SQY  = 24'h000040,
        S_SQS  = 24'h000080,
        S_SQW  = 24'h000100,
        S_R2   = 24'h000200,
        S_R3A  = 24'h000400,
        S_R3B  = 24'h000800,
        S_NX   = 24'h001000,
        S_DXS  = 24'h002000,
        S_DXW  = 24'h004000,
        S_NY   = 24'h008000,
        S_DYS  = 24'h010000,
        S_DYW  = 24'h020000,
        S_VX   = 24'h040000,
        S_VY   = 24'h080000,
        S_SUM  = 24'h100000,
        S_W1   = 24'h200000,
        S_W2   = 24'h400000,
        S_OUT  = 24'h800000
    } state_t;

    // Configuration registers
    logic [DT_BITS-1:0]           time_step_reg;
    logic [GM_BITS-1:0]           central_gm_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic [BOX_BITS-1:0]          box_size_reg;
    logic [CNT_BITS-1:0]          active_count_reg;

    // Control
    state_t                   state_reg, state_next;
    logic [AW-1:0]            idx_reg;
    logic [CNT_BITS-1:0]      n_reg;
    logic [CNT_BITS-1:0]      n_clamped;
    logic [MAX_PARTICLES-1:0] fresh_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_data_reg;
    logic                     req_fire;
    logic                     load_ok;
    logic                     out_free;
    logic                     is_last;

    // Datapath
    entry_t                       entry_reg;
    entry_t                       ram_wdata;
    entry_t                       ram_rdata;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [DT_BITS-1:0]           dt2_reg;
    logic [K_BITS-1:0]            k_reg;
    logic signed [D_BITS-1:0]     dx_reg, dy_reg;
    logic [D_BITS-1:0]            ax_reg, ay_reg;
    logic signed [D_BITS-1:0]     dx_now, dy_now;
    logic [SQ_BITS-1:0]           sq_reg;
    logic [ROOT_BITS-1:0]         rq_reg;
    logic [SQ_BITS-1:0]           r2_reg;
    logic [DEN_BITS-1:0]          den_reg;
    logic [MUL_BITS-1:0]          num_reg;
    logic signed [SUM_BITS-1:0]   tx_reg, ty_reg;
    logic signed [SUM_BITS-1:0]   vdx_reg, vdy_reg;
    logic signed [SUM_BITS-1:0]   px_reg, py_reg;
    logic signed [SUM_BITS-1:0]   box_s;
    logic signed [SUM_BITS-1:0]   wx, wy;
    logic [COORD_BITS-1:0]        new_x_reg, new_y_reg;
    logic [COORD_BITS-1:0]        vmag;
    logic                         vneg;
    logic signed [SUM_BITS-1:0]   vterm;
    logic signed [SUM_BITS-1:0]   cx_s, cy_s, prx_s, pry_s;

    // Shared multiplier
    logic [K_BITS-1:0]            mul_a;
    logic [D_BITS-1:0]            mul_b;
    logic [MUL_BITS-1:0]          mul_p;

    // Iterative units
    logic                         sqrt_done;
    logic [ROOT_BITS-1:0]         sqrt_root;
    logic                         div_done;
    logic [TERM_BITS-1:0]         div_quo;
    logic signed [SUM_BITS-1:0]   quo_s;
    logic                         zero_term;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign load_ok   = ({1'b0, req_data.slot} < MAX_CNT);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign is_last   = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == n_reg);
    assign n_clamped = (active_count_reg > MAX_CNT) ? MAX_CNT : active_count_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= RST_TIME_STEP;
            central_gm_reg   <= RST_CENTRAL_GM;
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            box_size_reg     <= RST_BOX_SIZE;
            active_count_reg <= RST_ACTIVE_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:    time_step_reg    <= cfg_data[DT_BITS-1:0];
                REG_CENTRAL_GM:   central_gm_reg   <= cfg_data[GM_BITS-1:0];
                REG_CENTER_X:     center_x_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_BITS-1:0];
                REG_BOX_SIZE:     box_size_reg     <= cfg_data[BOX_BITS-1:0];
                REG_ACTIVE_COUNT: active_count_reg <= cfg_data[CNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req_data.command == CMD_STEP) && (n_clamped != '0))
                begin
                    state_next = S_K1;
                end
            end
            S_K1:  state_next = S_K2;
            S_K2:  state_next = S_RD;
            S_RD:  state_next = S_LD;
            S_LD:  state_next = S_SQX;
            S_SQX: state_next = S_SQY;
            S_SQY: state_next = S_SQS;
            S_SQS: state_next = S_SQW;
            S_SQW: state_next = sqrt_done ? S_R2 : S_SQW;
            S_R2:  state_next = S_R3A;
            S_R3A: state_next = S_R3B;
            S_R3B: state_next = S_NX;
            S_NX:  state_next = S_DXS;
            S_DXS: state_next = S_DXW;
            S_DXW: state_next = div_done ? S_NY : S_DXW;
            S_NY:  state_next = S_DYS;
            S_DYS: state_next = S_DYW;
            S_DYW: state_next = div_done ? S_VX : S_DYW;
            S_VX:  state_next = S_VY;
            S_VY:  state_next = S_SUM;
            S_SUM: state_next = S_W1;
            S_W1:  state_next = S_W2;
            S_W2:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            fresh_reg     <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (req_fire && (req_data.command == CMD_LOAD) && load_ok)
            begin
                fresh_reg[req_data.slot[AW-1:0]] <= 1'b1;
            end
            if (req_fire && (req_data.command == CMD_STEP))
            begin
                idx_reg <= '0;
                n_reg   <= n_clamped;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                fresh_reg[idx_reg] <= 1'b0;
                if (!is_last)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            rsp_data_reg.out_slot     <= SLOT_BITS'(idx_reg);
            rsp_data_reg.new_x        <= new_x_reg;
            rsp_data_reg.new_y        <= new_y_reg;
            rsp_data_reg.last_of_step <= is_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Particle RAM: loads write from idle, the step writes back in S_OUT
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_OUT)
        begin
            ram_we           = out_free;
            ram_waddr        = idx_reg;
            ram_wdata.cur_x  = new_x_reg;
            ram_wdata.cur_y  = new_y_reg;
            ram_wdata.prev_x = entry_reg.cur_x;
            ram_wdata.prev_y = entry_reg.cur_y;
            ram_wdata.vel_x  = entry_reg.vel_x;
            ram_wdata.vel_y  = entry_reg.vel_y;
        end
        else
        begin
            ram_we           = req_fire && (req_data.command == CMD_LOAD) && load_ok;
            ram_waddr        = req_data.slot[AW-1:0];
            ram_wdata.cur_x  = req_data.load_x;
            ram_wdata.cur_y  = req_data.load_y;
            ram_wdata.prev_x = '0;
            ram_wdata.prev_y = '0;
            ram_wdata.vel_x  = req_data.load_vx;
            ram_wdata.vel_y  = req_data.load_vy;
        end
    end

    vcms_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_PARTICLES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == S_RD),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        vneg = (state_reg == S_VY) ? entry_reg.vel_y[COORD_BITS-1] :
                                     entry_reg.vel_x[COORD_BITS-1];
        vmag = (state_reg == S_VY) ? entry_reg.vel_y : entry_reg.vel_x;
        if (vneg)
        begin
            vmag = -vmag;
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_K1:
            begin
                mul_a = K_BITS'(time_step_reg);
                mul_b = D_BITS'(time_step_reg);
            end
            S_K2:
            begin
                mul_a = central_gm_reg[GM_BITS-1:12];
                mul_b = D_BITS'(dt2_reg);
            end
            S_SQX:
            begin
                mul_a = K_BITS'(ax_reg);
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = K_BITS'(ay_reg);
                mul_b = ay_reg;
            end
            S_R2:
            begin
                mul_a = K_BITS'(rq_reg);
                mul_b = D_BITS'(rq_reg);
            end
            S_R3A:
            begin
                mul_a = K_BITS'(r2_reg[31:0]);
                mul_b = D_BITS'(rq_reg);
            end
            S_R3B:
            begin
                mul_a = K_BITS'(r2_reg[63:32]);
                mul_b = D_BITS'(rq_reg);
            end
            S_NX:
            begin
                mul_a = k_reg;
                mul_b = ax_reg;
            end
            S_NY:
            begin
                mul_a = k_reg;
                mul_b = ay_reg;
            end
            S_VX, S_VY:
            begin
                mul_a = K_BITS'(vmag);
                mul_b = D_BITS'(time_step_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

    // Velocity term, truncated toward zero
    assign vterm = vneg ? -$signed(SUM_BITS'(mul_p[55:24])) :
                          $signed(SUM_BITS'(mul_p[55:24]));

    // ------------------------------------------------------------------
    // Per-particle datapath
    // ------------------------------------------------------------------
    assign dx_now = $signed({ram_rdata.cur_x[COORD_BITS-1], ram_rdata.cur_x}) -
                    $signed({center_x_reg[COORD_BITS-1], center_x_reg});
    assign dy_now = $signed({ram_rdata.cur_y[COORD_BITS-1], ram_rdata.cur_y}) -
                    $signed({center_y_reg[COORD_BITS-1], center_y_reg});

    assign quo_s     = $signed(SUM_BITS'(div_quo));
    assign zero_term = (rq_reg == '0) ||
                       ((state_reg == S_DXW) ? (dx_reg == '0) : (dy_reg == '0));

    assign cx_s  = SUM_BITS'($signed(entry_reg.cur_x));
    assign cy_s  = SUM_BITS'($signed(entry_reg.cur_y));
    assign prx_s = SUM_BITS'($signed(entry_reg.prev_x));
    assign pry_s = SUM_BITS'($signed(entry_reg.prev_y));
    assign box_s = $signed(SUM_BITS'(box_size_reg));

    // Second half of the wrap: lift negatives back into the box
    assign wx = (px_reg < 0) ? px_reg + box_s : px_reg;
    assign wy = (py_reg < 0) ? py_reg + box_s : py_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_K1:  dt2_reg <= mul_p[47:24];
            S_K2:  k_reg   <= mul_p[59:24];
            S_LD:
            begin
                entry_reg <= ram_rdata;
                dx_reg    <= dx_now;
                dy_reg    <= dy_now;
                ax_reg    <= dx_now[D_BITS-1] ? D_BITS'(-dx_now) : D_BITS'(dx_now);
                ay_reg    <= dy_now[D_BITS-1] ? D_BITS'(-dy_now) : D_BITS'(dy_now);
            end
            S_SQX: sq_reg <= mul_p[SQ_BITS+1:2];
            S_SQY: sq_reg <= sq_reg + mul_p[SQ_BITS+1:2];
            S_SQW:
            begin
                if (sqrt_done)
                begin
                    rq_reg <= sqrt_root;
                end
            end
            S_R2:  r2_reg  <= mul_p[SQ_BITS-1:0];
            S_R3A: den_reg <= DEN_BITS'(mul_p[SQ_BITS-1:0]);
            S_R3B: den_reg <= den_reg + {mul_p[SQ_BITS-1:0], 32'd0};
            S_NX, S_NY: num_reg <= mul_p;
            S_DXW:
            begin
                if (div_done)
                begin
                    tx_reg <= zero_term ? '0 : (dx_reg[D_BITS-1] ? quo_s : -quo_s);
                end
            end
            S_DYW:
            begin
                if (div_done)
                begin
                    ty_reg <= zero_term ? '0 : (dy_reg[D_BITS-1] ? quo_s : -quo_s);
                end
            end
            S_VX:  vdx_reg <= vterm;
            S_VY:  vdy_reg <= vterm;
            S_SUM:
            begin
                if (fresh_reg[idx_reg])
                begin
                    px_reg <= cx_s + vdx_reg + tx_reg;
                    py_reg <= cy_s + vdy_reg + ty_reg;
                end
                else
                begin
                    px_reg <= (cx_s <<< 1) - prx_s + tx_reg;
                    py_reg <= (cy_s <<< 1) - pry_s + ty_reg;
                end
            end
            S_W1:
            begin
                if (px_reg > box_s)
                begin
                    px_reg <= px_reg - box_s;
                end
                if (py_reg > box_s)
                begin
                    py_reg <= py_reg - box_s;
                end
            end
            S_W2:
            begin
                new_x_reg <= (wx > SAT_HI) ? SAT_HI[COORD_BITS-1:0] :
                             (wx < SAT_LO) ? SAT_LO[COORD_BITS-1:0] : wx[COORD_BITS-1:0];
                new_y_reg <= (wy > SAT_HI) ? SAT_HI[COORD_BITS-1:0] :
                             (wy < SAT_LO) ? SAT_LO[COORD_BITS-1:0] : wy[COORD_BITS-1:0];
            end
            default: ;
        endcase
    end

    vcms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQS),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    vcms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == S_DXS) || (state_reg == S_DYS)),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule

[rtl/core/vcms_ram.sv]
// ----------------------------------------------------------------------------
// vcms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vcms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/vcms_sqrt.sv]
// ----------------------------------------------------------------------------
// vcms_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vcms_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vcms_pkg::SQ_BITS-1:0]    radicand,
    output logic                            done,
    output logic [vcms_pkg::ROOT_BITS-1:0]  root
);
    import vcms_pkg::*;

    logic [SQ_BITS-1:0] rem_reg;
    logic [SQ_BITS-1:0] res_reg;
    logic [SQ_BITS-1:0] bit_reg;
    logic [SQ_BITS-1:0] trial;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= SQ_BITS'(1) << (SQ_BITS - 2);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_BITS-1:0];

endmodule

[rtl/core/vcms_div.sv]
// ----------------------------------------------------------------------------
// vcms_div
// Restoring divider for the acceleration term: floor(num * 2^37 / den),
// capped at 2^40. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module vcms_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vcms_pkg::MUL_BITS-1:0]   num,
    input  logic [vcms_pkg::DEN_BITS-1:0]   den,
    output logic                            done,
    output logic [vcms_pkg::TERM_BITS-1:0]  quo
);
    import vcms_pkg::*;

    localparam int REM_BITS = MUL_BITS + DIV_SHIFT;
    localparam int DSH_BITS = DEN_BITS + QUO_BITS - 1;

    logic [REM_BITS-1:0] rem_reg;
    logic [DSH_BITS-1:0] dsh_reg;
    logic [QUO_BITS-1:0] q_reg;
    logic [5:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                fits;

    assign fits = DSH_BITS'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QUO_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {num, {DIV_SHIFT{1'b0}}};
            dsh_reg <= {den, {(QUO_BITS - 1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg[REM_BITS-1:0];
            end
            q_reg   <= {q_reg[QUO_BITS-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // A set top bit, or anything above the cap, saturates
    assign quo  = (q_reg[QUO_BITS-1] || (q_reg[TERM_BITS-1:0] > TERM_CAP)) ?
                  TERM_CAP : q_reg[TERM_BITS-1:0];
    assign done = done_reg;

endmodule

[rtl/core/vcms_checker.sv]
// ----------------------------------------------------------------------------
// vcms_checker
// Port-level checks for the central-mass Verlet step core.
// ----------------------------------------------------------------------------
module vcms_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  vcms_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  vcms_pkg::rsp_t rsp_data
);
    import vcms_pkg::*;

    // No response beat is visible while reset is applied
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // A stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // A load never produces a response
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.command == CMD_LOAD) && !rsp_valid
        |=> !rsp_valid)
        else $error("response after a load");

    // A step in progress blocks new requests
    a_step_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last_of_step |-> !req_ready)
        else $error("request taken in the middle of a step");

endmodule

bind verlet_central_mass_step_core vcms_checker u_vcms_checker (.*);

[tb/tb_verlet_central_mass_step_core.sv]
// ----------------------------------------------------------------------------
// tb_verlet_central_mass_step_core
// Self-checking bench for the central-mass Verlet step core. Load and step
// beats go in on the request channel. A bit-exact predictor of the
// fixed-point gravity step keeps its own particle table and register copy,
// and queues the positions it expects. Every response beat is checked
// against the oldest queued one. Both channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_verlet_central_mass_step_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vcms_pkg::*;

    localparam int NPART = DEF_MAX_PARTICLES;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    req_t                      req_data;
    logic                      rsp_valid;
    logic                      rsp_ready;
    rsp_t                      rsp_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    verlet_central_mass_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies
    logic [DT_BITS-1:0]           dt_q;
    logic [GM_BITS-1:0]           gm_q;
    logic signed [COORD_BITS-1:0] cx_q;
    logic signed [COORD_BITS-1:0] cy_q;
    logic [BOX_BITS-1:0]          box_q;
    logic [CNT_BITS-1:0]          count_q;

    // Particle table copy
    logic signed [COORD_BITS-1:0] pos_x [NPART];
    logic signed [COORD_BITS-1:0] pos_y [NPART];
    logic signed [COORD_BITS-1:0] old_x [NPART];
    logic signed [COORD_BITS-1:0] old_y [NPART];
    logic signed [COORD_BITS-1:0] spd_x [NPART];
    logic signed [COORD_BITS-1:0] spd_y [NPART];
    bit                           is_fresh [NPART];
    bit                           loaded [NPART];

    rsp_t expected_positions[$];
    int   errors;
    int   send_idle;
    int   recv_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint pull_term(longint unsigned k, longint d, logic [127:0] den);
        logic [127:0]    num;
        logic [127:0]    q;
        longint unsigned mag;
        if (den == 0 || d == 0)
            return 0;
        mag = (d < 0) ? -d : d;
        num = (128'(k) * 128'(mag)) << DIV_SHIFT;
        q = num / den;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return (d > 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint wrap_coord(longint p);
        longint b;
        b = longint'(box_q);
        if (p > b)
            p -= b;
        if (p < 0)
            p += b;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p;
    endfunction

    function automatic longint dt_shift(longint v);
        return (v < 0) ? -((-v) >> 24) : (v >> 24);
    endfunction

    // Advance every active particle and queue the positions it lands on.
    function automatic void predict_gravity_step();
        longint unsigned dt2, k, ax, ay, rq;
        longint          dx, dy, tx, ty, nx, ny, dtl;
        logic [127:0]    den;
        int              n;
        rsp_t            r;
        n = (count_q > NPART) ? NPART : int'(count_q);
        dtl = longint'({40'd0, dt_q});
        dt2 = (64'(dt_q) * 64'(dt_q)) >> 24;
        k = ((64'(gm_q) >> 12) * dt2) >> 24;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(pos_x[i]) - longint'(cx_q);
            dy = longint'(pos_y[i]) - longint'(cy_q);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            rq = int_sqrt(((ax * ax) >> 2) + ((ay * ay) >> 2));
            den = 128'(rq) * 128'(rq) * 128'(rq);
            tx = pull_term(k, dx, den);
            ty = pull_term(k, dy, den);
            if (is_fresh[i])
            begin
                nx = longint'(pos_x[i]) + dt_shift(longint'(spd_x[i]) * dtl) + tx;
                ny = longint'(pos_y[i]) + dt_shift(longint'(spd_y[i]) * dtl) + ty;
            end
            else
            begin
                nx = 2 * longint'(pos_x[i]) - longint'(old_x[i]) + tx;
                ny = 2 * longint'(pos_y[i]) - longint'(old_y[i]) + ty;
            end
            nx = wrap_coord(nx);
            ny = wrap_coord(ny);
            old_x[i] = pos_x[i];
            old_y[i] = pos_y[i];
            pos_x[i] = nx[31:0];
            pos_y[i] = ny[31:0];
            is_fresh[i] = 0;
            r.out_slot = i[SLOT_BITS-1:0];
            r.new_x = nx[31:0];
            r.new_y = ny[31:0];
            r.last_of_step = (i == n - 1);
            expected_positions.push_back(r);
        end
    endfunction

    task automatic send_beat(req_t item);
        if ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!req_ready);
        if (item.command == CMD_STEP)
            predict_gravity_step();
        else
        begin
            pos_x[item.slot] = item.load_x;
            pos_y[item.slot] = item.load_y;
            spd_x[item.slot] = item.load_vx;
            spd_y[item.slot] = item.load_vy;
            is_fresh[item.slot] = 1;
            loaded[item.slot] = 1;
        end
    endtask

    task automatic load_particle(int s, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] vx, logic [31:0] vy);
        req_t item;
        item.command = CMD_LOAD;
        item.slot    = s[SLOT_BITS-1:0];
        item.load_x  = x;
        item.load_y  = y;
        item.load_vx = vx;
        item.load_vy = vy;
        send_beat(item);
    endtask

    task automatic step_all();
        req_t item;
        item = '0;
        item.command = CMD_STEP;
        item.load_x  = $urandom;
        item.load_vy = $urandom;
        item.slot    = SLOT_BITS'($urandom);
        send_beat(item);
    endtask

    // Hold the request side until every queued position has come back.
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIME_STEP:    dt_q = v[DT_BITS-1:0];
            REG_CENTRAL_GM:   gm_q = v[GM_BITS-1:0];
            REG_CENTER_X:     cx_q = v[31:0];
            REG_CENTER_Y:     cy_q = v[31:0];
            REG_BOX_SIZE:     box_q = v[BOX_BITS-1:0];
            REG_ACTIVE_COUNT: count_q = v[CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic random_particle(int s);
        logic [31:0] x, y;
        if ($urandom_range(3) == 0)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            // near the center, where gravity matters
            x = cx_q + $signed($urandom_range(67108864)) - 32'sd33554432;
            y = cy_q + $signed($urandom_range(67108864)) - 32'sd33554432;
        end
        if ($urandom_range(3) == 0)
            load_particle(s, x, y, $urandom, $urandom);
        else
            load_particle(s, x, y, $signed($urandom_range(33554432)) - 32'sd16777216,
                          $signed($urandom_range(33554432)) - 32'sd16777216);
    endtask

    task automatic fill_slots(int n);
        for (int s = 0; s < n && s < NPART; s++)
            if (!loaded[s])
                random_particle(s);
    endtask

    task automatic test_directed();
        write_reg(REG_ACTIVE_COUNT, 48'd4);
        load_particle(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        load_particle(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        load_particle(2, cx_q, cy_q, 32'h01000000, 32'hff000000);
        load_particle(3, cx_q + 32'h01000000, cy_q, 32'h0, 32'h00400000);
        step_all();
        step_all();
        // reload: fresh again; park one particle on the center
        load_particle(1, cx_q - 32'h00800000, cy_q + 32'h00800000, 32'h0, 32'h0);
        load_particle(2, cx_q, cy_q, 32'h0, 32'h0);
        step_all();
        drain();
        write_reg(REG_TIME_STEP, 48'hffffff);
        write_reg(REG_CENTRAL_GM, 48'hffffffffffff);
        write_reg(REG_BOX_SIZE, 48'h7fffffff);
        write_reg(REG_CENTER_X, 48'h80000000);
        write_reg(REG_CENTER_Y, 48'h7fffffff);
        step_all();
        step_all();
        drain();
        write_reg(REG_BOX_SIZE, 48'd0);
        write_reg(REG_TIME_STEP, 48'd0);
        write_reg(REG_CENTRAL_GM, 48'd0);
        step_all();
        drain();
        write_reg(REG_ACTIVE_COUNT, 48'd0);
        step_all();
        drain();
        write_reg(REG_ACTIVE_COUNT, 48'd1);
        write_reg(REG_BOX_SIZE, 48'd1);
        step_all();
        drain();
    endtask

    task automatic random_settings();
        int c;
        c = $urandom_range(19);
        write_reg(REG_TIME_STEP, ($urandom_range(3) == 0) ? 48'($urandom) : 48'($urandom_range(65536)));
        write_reg(REG_CENTRAL_GM, ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                                          : 48'($urandom_range(32'h7fffffff)));
        write_reg(REG_CENTER_X, 48'($signed($urandom_range(335544320)) - 32'sd167772160));
        write_reg(REG_CENTER_Y, ($urandom_range(7) == 0) ? 48'($urandom)
                                                         : 48'($urandom_range(167772160)));
        write_reg(REG_BOX_SIZE, ($urandom_range(7) == 0) ? 48'($urandom)
                                                         : 48'($urandom_range(1, 335544320)));
        if (c == 0)
            write_reg(REG_ACTIVE_COUNT, 48'd127);
        else if (c == 1)
            write_reg(REG_ACTIVE_COUNT, 48'd64);
        else
            write_reg(REG_ACTIVE_COUNT, 48'($urandom_range(1, 8)));
        fill_slots(int'(count_q));
    endtask

    task automatic test_random_phase(int snd, int rcv, int items);
        send_idle = snd;
        recv_idle = rcv;
        for (int i = 0; i < items; i++)
        begin
            if (i % 30 == 0)
            begin
                drain();
                random_settings();
            end
            if ($urandom_range(99) < 35)
                step_all();
            else
                random_particle($urandom_range(NPART - 1));
        end
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $display("%0t: unexpected beat %p", $time, rsp_data);
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_positions.pop_front();
                if (rsp_data.out_slot !== e.out_slot)
                begin
                    $display("%0t: out_slot expected %0d got %0d", $time, e.out_slot,
                             rsp_data.out_slot);
                    errors++;
                end
                if (rsp_data.new_x !== e.new_x)
                begin
                    $display("%0t: new_x expected %h got %h", $time, e.new_x, rsp_data.new_x);
                    errors++;
                end
                if (rsp_data.new_y !== e.new_y)
                begin
                    $display("%0t: new_y expected %h got %h", $time, e.new_y, rsp_data.new_y);
                    errors++;
                end
                if (rsp_data.last_of_step !== e.last_of_step)
                begin
                    $display("%0t: last_of_step expected %b got %b", $time, e.last_of_step,
                             rsp_data.last_of_step);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        errors    = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        dt_q    = RST_TIME_STEP;
        gm_q    = RST_CENTRAL_GM;
        cx_q    = RST_CENTER_X;
        cy_q    = RST_CENTER_Y;
        box_q   = RST_BOX_SIZE;
        count_q = RST_ACTIVE_COUNT;
        for (int s = 0; s < NPART; s++)
        begin
            is_fresh[s] = 1;
            loaded[s]   = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(23, 45, 110);
        test_random_phase(45, 23, 110);
        test_random_phase(0, 0, 110);
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
